// ===== rtl/hmtu_pkg.sv =====
// Shared types and codes of the homogeneous matrix transform unit.
package hmtu_pkg;

  localparam int DATA_W = 32;

  // Item modes.
  localparam logic [3:0] MODE_IDENTITY  = 4'd0;
  localparam logic [3:0] MODE_SET       = 4'd1;
  localparam logic [3:0] MODE_TRANSLATE = 4'd2;
  localparam logic [3:0] MODE_SCALE     = 4'd3;
  localparam logic [3:0] MODE_ROTX      = 4'd4;
  localparam logic [3:0] MODE_ROTY      = 4'd5;
  localparam logic [3:0] MODE_ROTZ      = 4'd6;
  localparam logic [3:0] MODE_SHEAR_XY  = 4'd7;
  localparam logic [3:0] MODE_SHEAR_Z   = 4'd8;
  localparam logic [3:0] MODE_PERSP     = 4'd9;
  localparam logic [3:0] MODE_XFORM     = 4'd10;

  // Control that travels with a pair of operands into the multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic first;
    logic last;
  } mac_ctrl_t;

  // One write into the matrix memory.
  typedef struct packed {
    logic              en;
    logic [3:0]        addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage

// ===== rtl/homogeneous_matrix_transform_unit.sv =====
// Top level of the homogeneous 4x4 matrix transform unit.
//
// The unit holds one 4x4 transform matrix of signed fixed-point elements with FRAC_BITS
// fraction bits, kept row-major in a 16-entry synchronous memory. Items arrive on the input
// channel (in_valid/in_ready); the mode picks identity, element set, a pre-multiply by an
// elementary matrix, or a point transform. Only the point transform makes a result, which
// leaves on the output channel (out_valid/out_ready) as four saturated coordinates.
//
// Identity, element set and unused modes finish in the transfer cycle itself; the next
// item is taken in the cycle after. A point transform streams the sixteen elements through
// the shared multiply-accumulate unit, one per cycle; once the four results are in and
// the output register is free, they are loaded into it, and out_valid rises in the same
// cycle that the next item can be taken. A pre-multiply works column by column: four
// memory reads to fetch a column, then sixteen multiply-accumulate steps.
// Both modes share the single multiplier and the one memory read port.
//
// Reset (and the identity mode) marks every entry as unwritten, and such an entry reads as
// the identity value, so the matrix is identity at once. A finished result sits in the
// output register while the next items are taken; only a later point transform waits, at
// its end, until that register has been taken by the receiver.
module homogeneous_matrix_transform_unit
  import hmtu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3:0]               mode,
  input  logic [1:0]               row_sel,
  input  logic [1:0]               col_sel,
  input  logic signed [DATA_W-1:0] val_a,
  input  logic signed [DATA_W-1:0] val_b,
  input  logic signed [DATA_W-1:0] val_c,
  input  logic signed [DATA_W-1:0] val_d,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_x,
  output logic signed [DATA_W-1:0] out_y,
  output logic signed [DATA_W-1:0] out_z,
  output logic signed [DATA_W-1:0] out_w
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_XF    = 3'd4;
  localparam logic [2:0] S_XWAIT = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic signed [DATA_W:0] ONE = (DATA_W + 1)'(1) << FRAC_BITS;

  // Element of the elementary matrix at row-major position idx for the given mode.
  function automatic logic signed [DATA_W:0] elem(
    input logic [3:0]               m,
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b,
    input logic signed [DATA_W-1:0] c,
    input logic [3:0]               idx
  );
    logic signed [DATA_W:0] a_x;
    logic signed [DATA_W:0] b_x;
    logic signed [DATA_W:0] c_x;
    logic signed [DATA_W:0] nb_x;
    logic signed [DATA_W:0] e;
    a_x  = {a[DATA_W-1], a};
    b_x  = {b[DATA_W-1], b};
    c_x  = {c[DATA_W-1], c};
    // The negated sine is kept at full width, so the most negative sine stays exact.
    nb_x = '0 - b_x;
    e    = (idx[1:0] == idx[3:2]) ? ONE : '0;
    unique case (m) inside
      MODE_TRANSLATE: begin
        case (idx)
          4'd3:    e = a_x;
          4'd7:    e = b_x;
          4'd11:   e = c_x;
          default: e = e;
        endcase
      end
      MODE_SCALE: begin
        case (idx)
          4'd0:    e = a_x;
          4'd5:    e = b_x;
          4'd10:   e = c_x;
          default: e = e;
        endcase
      end
      MODE_ROTX: begin
        case (idx)
          4'd5, 4'd10: e = a_x;
          4'd6:        e = nb_x;
          4'd9:        e = b_x;
          default:     e = e;
        endcase
      end
      MODE_ROTY: begin
        case (idx)
          4'd0, 4'd10: e = a_x;
          4'd2:        e = b_x;
          4'd8:        e = nb_x;
          default:     e = e;
        endcase
      end
      MODE_ROTZ: begin
        case (idx)
          4'd0, 4'd5: e = a_x;
          4'd1:       e = nb_x;
          4'd4:       e = b_x;
          default:    e = e;
        endcase
      end
      MODE_SHEAR_XY: begin
        case (idx)
          4'd1:    e = a_x;
          4'd4:    e = b_x;
          default: e = e;
        endcase
      end
      MODE_SHEAR_Z: begin
        case (idx)
          4'd2:    e = a_x;
          4'd6:    e = b_x;
          default: e = e;
        endcase
      end
      MODE_PERSP: begin
        if (idx == 4'd14) begin
          e = a_x;
        end
      end
      default: e = e;
    endcase
    return e;
  endfunction

  logic [2:0]               state;
  logic [3:0]               mode_q;
  logic signed [DATA_W-1:0] a_q;
  logic signed [DATA_W-1:0] b_q;
  logic signed [DATA_W-1:0] c_q;
  logic signed [DATA_W-1:0] p [4];
  logic signed [DATA_W-1:0] col [4];
  logic signed [DATA_W-1:0] res [4];
  logic [3:0]               cnt;
  logic [1:0]               jcol;
  logic [3:0]               wcnt;
  logic [1:0]               rcnt;
  logic                     col_pend;
  logic [1:0]               col_k;
  logic                     xf_pend;
  logic [1:0]               xf_k;
  logic                     accept;
  logic                     out_free;

  mem_wr_t                  wr;
  logic                     mem_clear;
  logic [3:0]               raddr;
  logic [DATA_W-1:0]        rdata;

  mac_ctrl_t                mac_ctrl;
  logic signed [DATA_W:0]   mac_a;
  logic signed [DATA_W-1:0] mac_b;
  logic signed [DATA_W-1:0] mac_res;
  logic                     mac_rv;
  logic                     premul_busy;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign premul_busy = (state == S_RD) || (state == S_MAC) || (state == S_DRAIN);

  // Memory access. Element writes land at transfer; pre-multiply results land as each
  // dot product closes, in column order, the last of a column while the next is being read.
  assign mem_clear = accept && (mode == MODE_IDENTITY);

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = {wcnt[1:0], wcnt[3:2]};
    wr.data = mac_res;
    if (accept && (mode == MODE_SET)) begin
      wr.en   = 1'b1;
      wr.addr = {row_sel, col_sel};
      wr.data = val_a;
    end else if (premul_busy && mac_rv) begin
      wr.en = 1'b1;
    end
  end

  assign raddr = (state == S_RD) ? {cnt[1:0], jcol} : cnt;

  hmtu_matrix_mem #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .clear(mem_clear),
    .wr   (wr),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    mac_ctrl.en    = 1'b0;
    mac_ctrl.first = 1'b0;
    mac_ctrl.last  = 1'b0;
    mac_a          = elem(mode_q, a_q, b_q, c_q, cnt);
    mac_b          = col[cnt[1:0]];
    if (state == S_MAC) begin
      mac_ctrl.en    = 1'b1;
      mac_ctrl.first = (cnt[1:0] == 2'd0);
      mac_ctrl.last  = (cnt[1:0] == 2'd3);
    end else if (xf_pend) begin
      mac_ctrl.en    = 1'b1;
      mac_ctrl.first = (xf_k == 2'd0);
      mac_ctrl.last  = (xf_k == 2'd3);
      mac_a          = {rdata[DATA_W-1], rdata};
      mac_b          = p[xf_k];
    end
  end

  hmtu_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .op_a     (mac_a),
    .op_b     (mac_b),
    .res      (mac_res),
    .res_valid(mac_rv)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      jcol      <= '0;
      wcnt      <= '0;
      rcnt      <= '0;
      col_pend  <= 1'b0;
      xf_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      col_pend <= (state == S_RD);
      xf_pend  <= (state == S_XF);
      // A new result may be loaded in the same cycle the previous one is taken.
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (premul_busy && mac_rv) begin
        wcnt <= wcnt + 4'd1;
      end
      if (((state == S_XF) || (state == S_XWAIT)) && mac_rv) begin
        rcnt <= rcnt + 2'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt  <= '0;
            jcol <= '0;
            case (mode) inside
              MODE_TRANSLATE, MODE_SCALE, MODE_ROTX, MODE_ROTY, MODE_ROTZ,
              MODE_SHEAR_XY, MODE_SHEAR_Z, MODE_PERSP: state <= S_RD;
              MODE_XFORM:                              state <= S_XF;
              default:                                 state <= S_IDLE;
            endcase
          end
        end
        S_RD: begin
          if (cnt[1:0] == 2'd3) begin
            cnt   <= '0;
            state <= S_MAC;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_MAC: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            jcol  <= jcol + 2'd1;
            state <= (jcol == 2'd3) ? S_DRAIN : S_RD;
          end
        end
        S_DRAIN: begin
          if (mac_rv && (wcnt == 4'd15)) begin
            state <= S_IDLE;
          end
        end
        S_XF: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= S_XWAIT;
          end
        end
        S_XWAIT: begin
          if (mac_rv && (rcnt == 2'd3)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      a_q    <= val_a;
      b_q    <= val_b;
      c_q    <= val_c;
      p[0]   <= val_a;
      p[1]   <= val_b;
      p[2]   <= val_c;
      p[3]   <= val_d;
    end
    if (state == S_RD) begin
      col_k <= cnt[1:0];
    end
    if (col_pend) begin
      col[col_k] <= rdata;
    end
    if (state == S_XF) begin
      xf_k <= cnt[1:0];
    end
    if (((state == S_XF) || (state == S_XWAIT)) && mac_rv) begin
      res[rcnt] <= mac_res;
    end
    if ((state == S_FIN) && out_free) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
      out_w <= res[3];
    end
  end

  // The block is idle only once every dot product has been written or captured.
  a_idle_no_mac: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mac_rv)
    else $error("multiply-accumulate result while idle");

  a_idle_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((wcnt == 4'd0) && (rcnt == 2'd0)))
    else $error("result counters not wrapped at end of item");

  // Writes of a finished column never hit the column being fetched.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RD) && wr.en) |-> (wr.addr[1:0] != jcol))
    else $error("write to the column under read");

  a_one_feed: assert property (@(posedge clk) disable iff (rst)
    !((state == S_MAC) && xf_pend))
    else $error("two operand sources at the multiply-accumulate unit");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && out_free) |=> (out_valid && (state == S_IDLE)))
    else $error("finished result not presented");

endmodule

// ===== rtl/hmtu_matrix_mem.sv =====
// Matrix store: 16-entry synchronous memory with per-entry valid bits over identity.
module hmtu_matrix_mem
  import hmtu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  mem_wr_t           wr,
  input  logic [3:0]        raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic [DATA_W-1:0] mem [16];
  logic [15:0]       valid;
  logic [DATA_W-1:0] rdata_raw;
  logic              rvalid;
  logic [3:0]        ridx;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_raw <= mem[raddr];
    ridx      <= raddr;
  end

  // An entry that has not been written since reset or identity reads as identity.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= valid[raddr];
      if (clear) begin
        valid <= '0;
      end else if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  assign rdata = rvalid ? rdata_raw : ((ridx[1:0] == ridx[3:2]) ? ONE : '0);

endmodule

// ===== rtl/hmtu_mac.sv =====
// Shared multiply-accumulate unit: floored fixed-point products, exact sum, saturation.
module hmtu_mac
  import hmtu_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [DATA_W:0]   op_a,
  input  logic signed [DATA_W-1:0] op_b,
  output logic signed [DATA_W-1:0] res,
  output logic                     res_valid
);

  localparam int PROD_W = 2 * DATA_W + 1;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int ACC_W  = SH_W + 2;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sh0000_0000_8000_0000);

  logic signed [PROD_W-1:0] prod;
  logic signed [SH_W-1:0]   prod_sh;
  logic signed [ACC_W-1:0]  acc;
  logic                     pv;
  logic                     pfirst;
  logic                     plast;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      pv        <= ctrl.en;
      res_valid <= pv && plast;
    end
  end

  // The arithmetic shift of the product floors toward minus infinity.
  assign prod_sh = prod[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    prod   <= op_a * op_b;
    pfirst <= ctrl.first;
    plast  <= ctrl.last;
    if (pv) begin
      acc <= (pfirst ? '0 : acc) + ACC_W'(prod_sh);
    end
  end

  always_comb begin
    if (acc > SAT_MAX) begin
      res = SAT_MAX[DATA_W-1:0];
    end else if (acc < SAT_MIN) begin
      res = SAT_MIN[DATA_W-1:0];
    end else begin
      res = acc[DATA_W-1:0];
    end
  end

endmodule
